// ===== rtl/lsb_pkg.sv =====
// Package for the status LED blinker: widths, register and mode codes,
// configuration struct and small counter helpers. No dependencies.
package lsb_pkg;

  localparam int CountBits = 16;   // elapsed and hold counters
  localparam int RegBits   = 16;   // configuration register width
  localparam int IdxBits   = 3;    // configuration register index width
  localparam int CmpBits   = (CountBits > RegBits) ? CountBits : RegBits;

  typedef logic [CountBits-1:0] count_t;
  typedef logic [RegBits-1:0]   reg_t;
  typedef logic [CmpBits-1:0]   cmp_t;

  localparam count_t CntMax = '1;

  // no-connection pattern boundaries, in ticks
  localparam cmp_t PatLit1End  = cmp_t'(1000);
  localparam cmp_t PatDark1End = cmp_t'(1500);
  localparam cmp_t PatLit2End  = cmp_t'(2000);
  localparam cmp_t PatDark2End = cmp_t'(2500);

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_ON     = 3'd1,
    MODE_NOCONN = 3'd2,
    MODE_REC    = 3'd3,
    MODE_FAST   = 3'd4
  } led_mode_e;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_ON        = 3'd1,
    CMD_NOCONN    = 3'd2,
    CMD_REC_START = 3'd3,
    CMD_REC_STOP  = 3'd4,
    CMD_OFF       = 3'd5
  } cmd_e;

  typedef enum logic [IdxBits-1:0] {
    REG_LONG_PRESS     = 3'd0,
    REG_FAST_TOGGLE    = 3'd1,
    REG_FAST_DURATION  = 3'd2,
    REG_RECORD_TOGGLE  = 3'd3,
    REG_PATTERN_PERIOD = 3'd4
  } reg_idx_e;

  localparam reg_t LongPressRst     = reg_t'(3000);
  localparam reg_t FastToggleRst    = reg_t'(333);
  localparam reg_t FastDurationRst  = reg_t'(5000);
  localparam reg_t RecordToggleRst  = reg_t'(500);
  localparam reg_t PatternPeriodRst = reg_t'(5000);

  typedef struct packed {
    reg_t long_press;
    reg_t fast_toggle;
    reg_t fast_duration;
    reg_t record_toggle;
    reg_t pattern_period;
  } cfg_t;

  function automatic count_t sat_inc(count_t v);
    return (v == CntMax) ? v : v + count_t'(1);
  endfunction

endpackage

// ===== rtl/lsb_if.sv =====
// Handshake channels of the status LED blinker: tick input and result output.
// No dependencies.
interface lsb_in_if;
  logic valid;
  logic ready;
  logic touch_level;
  logic [2:0] mode;

  modport source (output valid, output touch_level, output mode, input ready);
  modport sink   (input valid, input touch_level, input mode, output ready);
endinterface

interface lsb_out_if;
  logic valid;
  logic ready;
  logic led_level;
  logic [2:0] mode_now;
  logic recording_active;

  modport source (output valid, output led_level, output mode_now,
                  output recording_active, input ready);
  modport sink   (input valid, input led_level, input mode_now,
                  input recording_active, output ready);
endinterface

// ===== rtl/lsb_cfg_regs.sv =====
// Configuration register file of the status LED blinker.
// Depends on lsb_pkg.
module lsb_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [lsb_pkg::IdxBits-1:0] cfg_idx_i,
  input  lsb_pkg::reg_t          cfg_data_i,
  output lsb_pkg::cfg_t          cfg_o
);
  import lsb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LONG_PRESS:     cfg_d.long_press     = cfg_data_i;
        REG_FAST_TOGGLE:    cfg_d.fast_toggle    = cfg_data_i;
        REG_FAST_DURATION:  cfg_d.fast_duration  = cfg_data_i;
        REG_RECORD_TOGGLE:  cfg_d.record_toggle  = cfg_data_i;
        REG_PATTERN_PERIOD: cfg_d.pattern_period = cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press     <= LongPressRst;
      cfg_q.fast_toggle    <= FastToggleRst;
      cfg_q.fast_duration  <= FastDurationRst;
      cfg_q.record_toggle  <= RecordToggleRst;
      cfg_q.pattern_period <= PatternPeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/lsb_core.sv =====
// Per-tick state of the status LED blinker: mode, LED level, counters and
// the next-state logic for one item. Depends on lsb_pkg.
module lsb_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 acc_i,
  input  logic                 touch_i,
  input  logic [2:0]           cmd_i,
  input  lsb_pkg::cfg_t        cfg_i,
  output logic                 led_o,
  output lsb_pkg::led_mode_e   mode_o,
  output logic                 rec_o
);
  import lsb_pkg::*;

  led_mode_e mode_q, mode_d;
  logic      led_q, led_d;
  count_t    since_q, since_d;
  count_t    fast_q, fast_d;
  count_t    hold_q, hold_d;
  logic      fired_q, fired_d;
  logic      rec_q, rec_d;

  count_t    since_inc;
  cmp_t      e;

  always_comb begin
    since_inc = sat_inc(since_q);
    mode_d    = mode_q;
    led_d     = led_q;
    since_d   = since_inc;
    fast_d    = sat_inc(fast_q);
    hold_d    = hold_q;
    fired_d   = fired_q;
    rec_d     = rec_q;

    // command first
    case (cmd_i)
      CMD_ON:        begin mode_d = MODE_ON;     since_d = CntMax; end
      CMD_NOCONN:    begin mode_d = MODE_NOCONN; since_d = CntMax; end
      CMD_REC_START: begin rec_d = 1'b1; mode_d = MODE_REC; since_d = CntMax; end
      CMD_REC_STOP:  begin rec_d = 1'b0; mode_d = MODE_ON;  since_d = CntMax; end
      CMD_OFF:       begin mode_d = MODE_OFF;    since_d = CntMax; end
      default: ;
    endcase

    // long press fires once per press
    if (touch_i) begin
      hold_d = sat_inc(hold_q);
      if ((cmp_t'(hold_d) > cmp_t'(cfg_i.long_press)) && !fired_q) begin
        fired_d = 1'b1;
        mode_d  = MODE_FAST;
        since_d = CntMax;
        fast_d  = '0;
      end
    end else begin
      hold_d  = '0;
      fired_d = 1'b0;
    end

    e = cmp_t'(since_d);
    unique case (mode_d)
      MODE_OFF: led_d = 1'b0;
      MODE_ON:  led_d = 1'b1;
      MODE_NOCONN: begin
        // between the last dark stretch and the period end the LED holds
        if (e < PatLit1End)           led_d = 1'b1;
        else if (e < PatDark1End)     led_d = 1'b0;
        else if (e < PatLit2End)      led_d = 1'b1;
        else if (e < PatDark2End)     led_d = 1'b0;
        else if ((e > cmp_t'(cfg_i.pattern_period)) || (since_d == CntMax))
          since_d = '0;
      end
      MODE_REC: begin
        if (e >= cmp_t'(cfg_i.record_toggle)) begin
          led_d   = ~led_q;
          since_d = '0;
        end
      end
      MODE_FAST: begin
        if (e >= cmp_t'(cfg_i.fast_toggle)) begin
          led_d   = ~led_q;
          since_d = '0;
        end
        if (cmp_t'(fast_d) >= cmp_t'(cfg_i.fast_duration)) begin
          mode_d  = MODE_ON;
          since_d = CntMax;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ON;
      led_q   <= 1'b1;
      since_q <= CntMax;
      fast_q  <= '0;
      hold_q  <= '0;
      fired_q <= 1'b0;
      rec_q   <= 1'b0;
    end else if (acc_i) begin
      mode_q  <= mode_d;
      led_q   <= led_d;
      since_q <= since_d;
      fast_q  <= fast_d;
      hold_q  <= hold_d;
      fired_q <= fired_d;
      rec_q   <= rec_d;
    end
  end

  // result of the item being accepted this cycle
  assign led_o  = led_d;
  assign mode_o = mode_d;
  assign rec_o  = rec_d;

  a_off_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_OFF |-> !led_q)
    else $error("LED lit while mode is off");

  a_fired_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fired_q |-> hold_q != '0)
    else $error("long press marked fired without a held touch");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !touch_i |=> hold_q == '0 && !fired_q)
    else $error("touch release did not clear hold state");

  a_rec_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rec_q ##1 rec_q |-> $past(acc_i && cmd_i == CMD_REC_START))
    else $error("recording flag set without a start command");

endmodule

// ===== rtl/led_status_blinker_with_long_press.sv =====
// Top level of the status LED blinker with long-press fast blink.
// Depends on lsb_pkg, lsb_if, lsb_cfg_regs and lsb_core.
//
// One input item is one millisecond tick: the touch level and a mode command
// (none, steady on, no connection, start recording, stop recording, off).
// Each item yields exactly one result item: the LED level after the tick,
// the current mode (off, on, no connection, recording, fast blink) and the
// recording flag. The whole tick update is combinational logic between the
// state registers and the result register, so an item is taken every clock
// while the result register is empty or being drained in the same cycle;
// the result is valid in the cycle after accept. Holding touch past
// long_press_ms enters fast blink once per press; fast blink toggles every
// fast_toggle_ms and drops back to steady on after fast_duration_ms. All
// tick counters saturate at all ones. Configuration registers (index 0..4:
// long press, fast toggle, fast duration, record toggle, pattern period)
// are written through cfg_we_i/cfg_idx_i/cfg_data_i by the user only while no
// item is in flight, unenforced; other indexes are ignored. No reset sweep.
module led_status_blinker_with_long_press (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lsb_pkg::IdxBits-1:0] cfg_idx_i,
  input  lsb_pkg::reg_t               cfg_data_i,
  lsb_in_if.sink                      in_i,
  lsb_out_if.source                   out_o
);
  import lsb_pkg::*;

  cfg_t      cfg;
  logic      acc;
  logic      led_nxt;
  led_mode_e mode_nxt;
  logic      rec_nxt;

  logic      out_valid_q;
  logic      led_q;
  led_mode_e mode_q;
  logic      rec_q;

  lsb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // take a new item whenever the result slot frees up this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;

  lsb_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .touch_i (in_i.touch_level),
    .cmd_i   (in_i.mode),
    .cfg_i   (cfg),
    .led_o   (led_nxt),
    .mode_o  (mode_nxt),
    .rec_o   (rec_nxt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      led_q  <= led_nxt;
      mode_q <= mode_nxt;
      rec_q  <= rec_nxt;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.led_level        = led_q;
  assign out_o.mode_now         = mode_q;
  assign out_o.recording_active = rec_q;

endmodule
